[design/f2pcm_pkg.sv]
// Formats, byte counts and conversion functions for the float-to-PCM sample converter.
package f2pcm_pkg;

  typedef enum logic [1:0] {
    FMT_FLOAT32 = 2'd0,
    FMT_INT32   = 2'd1,
    FMT_INT24   = 2'd2,
    FMT_INT16   = 2'd3
  } fmt_t;

  localparam logic [2:0] BYTES_FLOAT32 = 3'd4;
  localparam logic [2:0] BYTES_INT32   = 3'd4;
  localparam logic [2:0] BYTES_INT24   = 3'd3;
  localparam logic [2:0] BYTES_INT16   = 3'd2;

  localparam logic [7:0]  EXP_ONE    = 8'd127;
  localparam logic [7:0]  EXP_INT32  = 8'd119;
  localparam logic [7:0]  EXP_NAN    = 8'd255;
  localparam logic [14:0] SCALE_I16  = 15'd32767;
  localparam logic [31:0] I32_POS_FS = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_NEG_FS = 32'h8000_0000;

  function automatic logic is_nan(input logic [31:0] b);
    is_nan = (b[30:23] == EXP_NAN) && (b[22:0] != 23'd0);
  endfunction

  // trunc(v * 2^31) with saturation at +/-1.0
  function automatic logic [31:0] to_i32(input logic [31:0] b);
    logic [7:0]  ex;
    logic [23:0] m;
    logic [7:0]  rsh;
    logic [30:0] mag;
    logic [31:0] res;
    ex  = b[30:23];
    m   = {1'b1, b[22:0]};
    rsh = 8'd0;
    mag = 31'd0;
    if (ex == 8'd0) begin
      mag = 31'd0;
    end else if (ex >= EXP_INT32) begin
      mag = {7'd0, m} << (ex - EXP_INT32);
    end else begin
      rsh = EXP_INT32 - ex;
      mag = (rsh >= 8'd24) ? 31'd0 : ({7'd0, m} >> rsh[4:0]);
    end
    res = b[31] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    if (is_nan(b)) begin
      to_i32 = 32'd0;
    end else if (ex >= EXP_ONE) begin
      to_i32 = b[31] ? I32_NEG_FS : I32_POS_FS;
    end else begin
      to_i32 = res;
    end
  endfunction

  // trunc(round_ne(clamp(v) * 32767.0f))
  function automatic logic [15:0] to_i16(input logic [31:0] b);
    logic [7:0]  ex;
    logic [23:0] m;
    logic [38:0] p;
    logic [24:0] r;
    logic        g;
    logic        s;
    logic [39:0] q;
    logic [7:0]  sh;
    logic [14:0] mag;
    logic [15:0] res;
    ex = b[30:23];
    m  = {1'b1, b[22:0]};
    p  = m * SCALE_I16;
    if (p[38]) begin
      r = {1'b0, p[38:15]};
      g = p[14];
      s = |p[13:0];
    end else begin
      r = {1'b0, p[37:14]};
      g = p[13];
      s = |p[12:0];
    end
    if (g && (s || r[0])) begin
      r = r + 25'd1;
    end
    q   = p[38] ? ({15'd0, r} << 15) : ({15'd0, r} << 14);
    sh  = 8'd150 - ex;
    mag = (sh >= 8'd40) ? 15'd0 : 15'(q >> sh[5:0]);
    if (is_nan(b) || ex == 8'd0) begin
      mag = 15'd0;
    end else if (ex >= EXP_ONE) begin
      mag = SCALE_I16;
    end
    res    = {1'b0, mag};
    to_i16 = b[31] ? (16'd0 - res) : res;
  endfunction

endpackage

[design/float_to_pcm_sample_converter.sv]
// Float-to-PCM sample converter top level: input register, conversion logic, output register.
// One sample per cycle: a transfer is taken every clock while the output side does not
// stall; a sample passes the input register, then the result register. float32 passes bits
// through, int32/int24 truncate v*2^31 with saturation at +/-1.0, int16 clamps and rounds
// v*32767 to single precision before truncating. NaN gives zero for the integer formats.
module float_to_pcm_sample_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_sample_bits,
  input  logic        in_last_in_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic [2:0]  out_byte_count,
  output logic        out_last_in_block_res
);

  logic        s1_valid_r;
  logic [1:0]  s1_func_r;
  logic [31:0] s1_bits_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_count_r;
  logic        out_last_r;

  logic        adv2;
  logic        adv1;
  logic [31:0] i32;
  logic [31:0] word_nxt;
  logic [2:0]  count_nxt;

  assign adv2     = !out_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  always_comb begin
    i32 = f2pcm_pkg::to_i32(s1_bits_r);
    unique case (f2pcm_pkg::fmt_t'(s1_func_r))
      f2pcm_pkg::FMT_FLOAT32: begin
        word_nxt  = s1_bits_r;
        count_nxt = f2pcm_pkg::BYTES_FLOAT32;
      end
      f2pcm_pkg::FMT_INT32: begin
        word_nxt  = i32;
        count_nxt = f2pcm_pkg::BYTES_INT32;
      end
      f2pcm_pkg::FMT_INT24: begin
        word_nxt  = {8'd0, i32[31:8]};
        count_nxt = f2pcm_pkg::BYTES_INT24;
      end
      default: begin
        word_nxt  = {16'd0, f2pcm_pkg::to_i16(s1_bits_r)};
        count_nxt = f2pcm_pkg::BYTES_INT16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_func_r <= in_func;
      s1_bits_r <= in_sample_bits;
      s1_last_r <= in_last_in_block;
    end
    if (adv2) begin
      out_word_r  <= word_nxt;
      out_count_r <= count_nxt;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_word              = out_word_r;
  assign out_byte_count        = out_count_r;
  assign out_last_in_block_res = out_last_r;

endmodule
